/* rtl/psrs_pkg.sv */
`timescale 1ns / 1ps
// Package for the printable string run scanner: widths, codes and record types.
package psrs_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int LENGTH_BITS = 12;
  localparam int NUMBER_BITS = 32;
  localparam int CFG_BITS    = 12;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] ZERO_BYTE      = 8'h00;
  localparam logic [7:0] PRINTABLE_LOW  = 8'h20;
  localparam logic [7:0] PRINTABLE_HIGH = 8'h7E;

  localparam logic [1:0] CFG_MIN_LENGTH       = 2'd0;
  localparam logic [1:0] CFG_MAX_ASCII_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAX_WIDE_LENGTH  = 2'd2;

  localparam logic [CFG_BITS-1:0] MIN_LENGTH_RESET = 12'd4;
  localparam logic [CFG_BITS-1:0] MAX_LENGTH_RESET = 12'd255;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ASCII = 2'd1,
    MODE_WIDE  = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t                  mode;
    logic                   skip;
    logic [LENGTH_BITS-1:0] count;
    logic [OFFSET_BITS-1:0] start;
  } scan_t;

  typedef struct packed {
    scan_t                  s;
    logic                   closed;
    logic                   kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] count;
  } ex_t;

  typedef struct packed {
    logic [NUMBER_BITS-1:0] num;
    logic [OFFSET_BITS-1:0] start;
    logic                   kind;
    logic [LENGTH_BITS-1:0] len;
    logic                   last;
  } rec_t;

  function automatic logic is_printable(logic [7:0] c);
    is_printable = (c >= PRINTABLE_LOW) && (c <= PRINTABLE_HIGH);
  endfunction

  function automatic logic [LENGTH_BITS-1:0] limit_of(logic [CFG_BITS-1:0] r);
    logic [LENGTH_BITS-1:0] v;
    v = (r == '0) ? LENGTH_BITS'(1) : LENGTH_BITS'(r);
    limit_of = v;
  endfunction

  // One character position of the scan.
  function automatic ex_t examine(scan_t s, logic [7:0] cur, logic has_next,
                                  logic [7:0] nxt, logic [OFFSET_BITS-1:0] pos,
                                  logic [LENGTH_BITS-1:0] lim_a,
                                  logic [LENGTH_BITS-1:0] lim_w);
    ex_t  r;
    logic pr;
    logic wide_char;
    logic cont;
    r        = '0;
    r.s      = s;
    r.start  = s.start;
    r.count  = s.count;
    r.kind   = (s.mode == MODE_WIDE);
    pr        = is_printable(cur);
    wide_char = has_next && (nxt == ZERO_BYTE) && pr;
    cont = ((s.mode == MODE_WIDE) && (s.count < lim_w) && wide_char) ||
           ((s.mode == MODE_ASCII) && (s.count < lim_a) && pr);
    if (s.skip) begin
      r.s.skip = 1'b0;
    end else if (cont) begin
      r.s.count = s.count + LENGTH_BITS'(1);
      r.s.skip  = (s.mode == MODE_WIDE);
    end else begin
      r.closed  = (s.mode != MODE_IDLE);
      r.s.mode  = MODE_IDLE;
      r.s.count = '0;
      if (wide_char) begin
        r.s.mode  = MODE_WIDE;
        r.s.start = pos;
        r.s.count = LENGTH_BITS'(1);
        r.s.skip  = 1'b1;
      end else if (pr) begin
        r.s.mode  = MODE_ASCII;
        r.s.start = pos;
        r.s.count = LENGTH_BITS'(1);
      end
    end
    examine = r;
  endfunction

endpackage

/* rtl/printable_string_run_scanner.sv */
`timescale 1ns / 1ps
// Top level of the printable string run scanner.
//
// Input channel: one file byte per item (data_byte, end_of_file), in_valid/in_stall.
// The byte flagged end_of_file is the last of a file; open runs are flushed and the
// offset and string counters restart at zero for the next file.
// Output channel: one record per item (string_number, start_offset, wide_kind,
// char_length, last_of_burst), out_valid/out_stall, from a four-entry queue.
// Config: cfg_write with cfg_index/cfg_data; write only while the block is idle.
// Flow: a byte passes the input register and the held byte register, where it is
// examined together with its successor; the records caused by an item are built
// from the input register and written to the queue when that item advances.
// Throughput: one byte per cycle while the output queue has room for two records;
// an item causes at most two; the single output port paces bursts of short runs.
// Reset: synchronous, clears scan state, counters, queue and restores the config
// defaults (min 4, max 255 for both kinds).
// Stall: when the receiver stalls, the queue fills and in_stall rises once the
// queue can no longer take two records; no item is lost.
module printable_string_run_scanner
  import psrs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_BITS-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_file,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [NUMBER_BITS-1:0] string_number,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic                   wide_kind,
  output logic [LENGTH_BITS-1:0] char_length,
  output logic                   last_of_burst
);

  logic [CFG_BITS-1:0] min_length;
  logic [CFG_BITS-1:0] max_ascii_length;
  logic [CFG_BITS-1:0] max_wide_length;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_eof;

  scan_t                  scan;
  scan_t                  scan_next;
  logic [7:0]             held_byte;
  logic                   held_valid;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] byte_position_next;
  logic [NUMBER_BITS-1:0] strings_found;
  logic [NUMBER_BITS-1:0] strings_found_next;

  rec_t                 q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] wr_ptr_1;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] q_count;
  logic [QCNT_BITS-1:0] q_count_next;

  logic                   room;
  logic                   advance;
  logic                   pop;
  logic [LENGTH_BITS-1:0] lim_a;
  logic [LENGTH_BITS-1:0] lim_w;
  logic [LENGTH_BITS-1:0] min_eff;
  ex_t                    e1;
  ex_t                    e2;
  ex_t                    e3;
  logic                   v1;
  logic                   v2;
  logic                   v3;
  ex_t                    first;
  ex_t                    second;
  logic [1:0]             n_rec;
  rec_t                   rec0;
  rec_t                   rec1;

  assign room     = (q_count <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign advance  = stage_valid && room;
  assign in_stall = stage_valid && !room;
  assign pop      = out_valid && !out_stall;

  assign lim_a   = limit_of(max_ascii_length);
  assign lim_w   = limit_of(max_wide_length);
  assign min_eff = limit_of(min_length);

  always_comb begin
    e1 = '0;
    e1.s = scan;
    if (held_valid) begin
      e1 = examine(scan, held_byte, 1'b1, stage_byte,
                   byte_position - OFFSET_BITS'(1), lim_a, lim_w);
    end
    e2 = examine(e1.s, stage_byte, 1'b0, ZERO_BYTE, byte_position, lim_a, lim_w);
    e3        = '0;
    e3.s      = e2.s;
    e3.closed = (e2.s.mode != MODE_IDLE);
    e3.kind   = (e2.s.mode == MODE_WIDE);
    e3.start  = e2.s.start;
    e3.count  = e2.s.count;

    v1 = e1.closed && (e1.count >= min_eff);
    v2 = stage_eof && e2.closed && (e2.count >= min_eff);
    v3 = stage_eof && e3.closed && (e3.count >= min_eff);

    first  = v1 ? e1 : (v2 ? e2 : e3);
    second = (v1 && v2) ? e2 : e3;
    if (v1 || v2 || v3) begin
      n_rec = ((v1 && v2) || (v1 && v3) || (v2 && v3)) ? 2'd2 : 2'd1;
    end else begin
      n_rec = 2'd0;
    end

    rec0.num   = strings_found + NUMBER_BITS'(1);
    rec0.start = first.start;
    rec0.kind  = first.kind;
    rec0.len   = first.count;
    rec0.last  = (n_rec == 2'd1);
    rec1.num   = strings_found + NUMBER_BITS'(2);
    rec1.start = second.start;
    rec1.kind  = second.kind;
    rec1.len   = second.count;
    rec1.last  = 1'b1;

    if (stage_eof) begin
      scan_next          = '0;
      byte_position_next = '0;
      strings_found_next = '0;
    end else begin
      scan_next          = e1.s;
      byte_position_next = byte_position + OFFSET_BITS'(1);
      strings_found_next = strings_found + NUMBER_BITS'(n_rec);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length       <= MIN_LENGTH_RESET;
      max_ascii_length <= MAX_LENGTH_RESET;
      max_wide_length  <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIN_LENGTH:       min_length       <= cfg_data;
        CFG_MAX_ASCII_LENGTH: max_ascii_length <= cfg_data;
        CFG_MAX_WIDE_LENGTH:  max_wide_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_byte <= data_byte;
      stage_eof  <= end_of_file;
    end
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan          <= '0;
      held_byte     <= '0;
      held_valid    <= 1'b0;
      byte_position <= '0;
      strings_found <= '0;
    end else if (advance) begin
      scan          <= scan_next;
      held_byte     <= stage_eof ? 8'h00 : stage_byte;
      held_valid    <= !stage_eof;
      byte_position <= byte_position_next;
      strings_found <= strings_found_next;
    end
  end

  // Result queue.
  assign wr_ptr_1 = wr_ptr + QPTR_BITS'(1);

  always_comb begin
    q_count_next = q_count;
    if (advance) begin
      q_count_next = q_count_next + QCNT_BITS'(n_rec);
    end
    if (pop) begin
      q_count_next = q_count_next - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(n_rec);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      q_count <= q_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (n_rec != 2'd0)) begin
      q[wr_ptr] <= rec0;
    end
    if (advance && (n_rec == 2'd2)) begin
      q[wr_ptr_1] <= rec1;
    end
  end

  assign out_valid     = (q_count != '0);
  assign string_number = q[rd_ptr].num;
  assign start_offset  = q[rd_ptr].start;
  assign wide_kind     = q[rd_ptr].kind;
  assign char_length   = q[rd_ptr].len;
  assign last_of_burst = q[rd_ptr].last;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !stage_valid)
    else $error("not empty after reset");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    advance && stage_eof |=> byte_position == '0 && strings_found == '0 && !held_valid)
    else $error("scan not restarted after end of file");

  a_burst_last: assert property (@(posedge clk) disable iff (rst)
    advance && (n_rec == 2'd2) |-> !rec0.last && rec1.num == rec0.num + NUMBER_BITS'(1))
    else $error("burst records out of order");
`endif

endmodule

/* tb/printable_string_run_scanner_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the printable string run scanner: byte stream in, run records out.
module printable_string_run_scanner_tb
  import psrs_pkg::*;
();

  localparam int MAX_BURST = 2;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PHASES = 9;
  localparam int PRESSURE_PHASE = 6;
  localparam int PHASE_ITEMS = 170;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [7:0] value;
    logic       eof;
  } file_byte_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [1:0]             cfg_index;
  logic [CFG_BITS-1:0]    cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             data_byte;
  logic                   end_of_file;
  logic                   out_valid;
  logic                   out_stall;
  logic [NUMBER_BITS-1:0] string_number;
  logic [OFFSET_BITS-1:0] start_offset;
  logic                   wide_kind;
  logic [LENGTH_BITS-1:0] char_length;
  logic                   last_of_burst;

  printable_string_run_scanner dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .end_of_file(end_of_file),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .string_number(string_number),
    .start_offset(start_offset),
    .wide_kind(wide_kind),
    .char_length(char_length),
    .last_of_burst(last_of_burst)
  );

  always #5 clk = ~clk;

  // Scanner model state
  logic [CFG_BITS-1:0]    min_len_cfg;
  logic [CFG_BITS-1:0]    max_ascii_cfg;
  logic [CFG_BITS-1:0]    max_wide_cfg;
  logic [7:0]             look_byte;
  logic                   look_valid;
  mode_t                  scan_mode;
  logic                   skip_high;
  logic [LENGTH_BITS-1:0] char_count;
  logic [OFFSET_BITS-1:0] run_origin;
  logic [OFFSET_BITS-1:0] next_offset;
  logic [NUMBER_BITS-1:0] found_count;
  rec_t                   burst[$];
  rec_t                   expected_records[$];

  file_byte_t  byte_queue[$];
  file_byte_t  next_byte;
  rec_t        want;
  logic        in_took;
  logic        out_took;
  int unsigned send_wait;
  int unsigned recv_wait;
  int unsigned send_gap_max;
  int unsigned recv_gap_max;
  int unsigned hold_cycles;
  int unsigned error_count;

  function automatic logic is_text(logic [7:0] c);
    return (c >= PRINTABLE_LOW) && (c <= PRINTABLE_HIGH);
  endfunction

  function automatic logic [LENGTH_BITS-1:0] run_limit(logic [CFG_BITS-1:0] r);
    return (r == '0) ? LENGTH_BITS'(1) : LENGTH_BITS'(r);
  endfunction

  function automatic void restart_file();
    look_byte   = '0;
    look_valid  = 1'b0;
    scan_mode   = MODE_IDLE;
    skip_high   = 1'b0;
    char_count  = '0;
    run_origin  = '0;
    next_offset = '0;
    found_count = '0;
  endfunction

  function automatic void record_run(logic kind, logic [OFFSET_BITS-1:0] origin,
                                     logic [LENGTH_BITS-1:0] count);
    rec_t r;
    if (count == '0 || count < min_len_cfg || burst.size() >= MAX_BURST) return;
    found_count = found_count + 1'b1;
    r.num   = found_count;
    r.start = origin;
    r.kind  = kind;
    r.len   = count;
    r.last  = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void close_open();
    if (scan_mode != MODE_IDLE) record_run(scan_mode == MODE_WIDE, run_origin, char_count);
    scan_mode  = MODE_IDLE;
    char_count = '0;
  endfunction

  function automatic void scan_char(logic [7:0] cur, logic has_next, logic [7:0] nxt,
                                    logic [OFFSET_BITS-1:0] pos);
    logic wide;
    wide = has_next && (nxt == ZERO_BYTE) && is_text(cur);
    if (skip_high) begin
      skip_high = 1'b0;
      return;
    end
    if (scan_mode == MODE_WIDE) begin
      if (char_count < run_limit(max_wide_cfg) && wide) begin
        char_count = char_count + 1'b1;
        skip_high  = 1'b1;
        return;
      end
      close_open();
    end else if (scan_mode == MODE_ASCII) begin
      if (char_count < run_limit(max_ascii_cfg) && is_text(cur)) begin
        char_count = char_count + 1'b1;
        return;
      end
      close_open();
    end
    if (wide) begin
      scan_mode  = MODE_WIDE;
      run_origin = pos;
      char_count = LENGTH_BITS'(1);
      skip_high  = 1'b1;
    end else if (is_text(cur)) begin
      scan_mode  = MODE_ASCII;
      run_origin = pos;
      char_count = LENGTH_BITS'(1);
    end
  endfunction

  function automatic void predict_records(logic [7:0] b, logic eof);
    rec_t tail;
    if (look_valid) scan_char(look_byte, 1'b1, b, next_offset - 1'b1);
    if (eof) begin
      scan_char(b, 1'b0, ZERO_BYTE, next_offset);
      close_open();
      restart_file();
    end else begin
      look_byte   = b;
      look_valid  = 1'b1;
      next_offset = next_offset + 1'b1;
    end
    if (burst.size() != 0) begin
      tail = burst.pop_back();
      tail.last = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[i]) expected_records.push_back(burst[i]);
    burst.delete();
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Monitor: model runs on accepted items, records checked in order
  always @(posedge clk) begin
    in_took  = !rst && in_valid && !in_stall;
    out_took = !rst && out_valid && !out_stall;
    if (out_took) begin
      if (expected_records.size() == 0) begin
        report_mismatch($sformatf("record %0d arrived with none expected", string_number));
      end else begin
        want = expected_records.pop_front();
        if (string_number !== want.num)
          report_mismatch($sformatf("string_number %0d, expected %0d", string_number, want.num));
        if (start_offset !== want.start)
          report_mismatch($sformatf("start_offset %0d, expected %0d", start_offset, want.start));
        if (wide_kind !== want.kind)
          report_mismatch($sformatf("wide_kind %0b, expected %0b", wide_kind, want.kind));
        if (char_length !== want.len)
          report_mismatch($sformatf("char_length %0d, expected %0d", char_length, want.len));
        if (last_of_burst !== want.last)
          report_mismatch($sformatf("last_of_burst %0b, expected %0b", last_of_burst, want.last));
      end
    end
    if (in_took) predict_records(data_byte, end_of_file);
  end

  // Byte driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_took) begin
        // item still waiting
      end else if (send_wait != 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (byte_queue.size() != 0) begin
        next_byte = byte_queue.pop_front();
        in_valid    <= 1'b1;
        data_byte   <= next_byte.value;
        end_of_file <= next_byte.eof;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted down once per cycle
  always @(posedge clk) begin
    if (!rst && hold_cycles != 0) hold_cycles--;
  end

  // Record receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) recv_wait = $urandom_range(0, recv_gap_max);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
      end else if (recv_wait != 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void push_item(logic [7:0] b, logic eof);
    byte_queue.push_back({b, eof});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(PRINTABLE_LOW, PRINTABLE_HIGH));
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_length();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_BITS'(1);
      2: return CFG_BITS'(2);
      3: return CFG_BITS'(3);
      4: return CFG_BITS'($urandom_range(4, 12));
      5: return '1;
      6: return MAX_LENGTH_RESET;
      default: return CFG_BITS'($urandom_range(1, 4095));
    endcase
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_MIN_LENGTH:       min_len_cfg   = val;
      CFG_MAX_ASCII_LENGTH: max_ascii_cfg = val;
      CFG_MAX_WIDE_LENGTH:  max_wide_cfg  = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_records.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed runs with random content, plus noise, broken wide runs and end-of-file bytes
  task automatic queue_random_bytes(int unsigned count);
    int unsigned made;
    int unsigned len;
    made = 0;
    while (made < count) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          len = $urandom_range(1, 12);
          repeat (len) push_item(text_byte(), 1'b0);
          made += len;
        end
        4, 5, 6: begin
          len = $urandom_range(1, 8);
          repeat (len) begin
            push_item(text_byte(), 1'b0);
            push_item(ZERO_BYTE, 1'b0);
          end
          made += 2 * len;
        end
        7: begin
          push_item(ZERO_BYTE, 1'b0);
          made += 1;
        end
        8: begin
          len = $urandom_range(1, 3);
          repeat (len) push_item(8'($urandom_range(0, 255)), 1'b0);
          made += len;
        end
        9: begin
          push_item(text_byte(), 1'b0);
          push_item(ZERO_BYTE, 1'b0);
          push_item(text_byte(), 1'b0);
          push_item(text_byte(), 1'b0);
          push_item(ZERO_BYTE, 1'b0);
          push_item(ZERO_BYTE, 1'b0);
          made += 6;
        end
        10: begin
          push_item(8'($urandom_range(0, 255)), 1'b1);
          made += 1;
        end
        default: begin
          push_item(text_byte(), 1'b1);
          made += 1;
        end
      endcase
    end
  endtask

  initial begin
    logic [CFG_BITS-1:0] mn;
    logic [CFG_BITS-1:0] ma;
    logic [CFG_BITS-1:0] mw;
    string word;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    end_of_file  = 1'b0;
    out_stall    = 1'b0;
    in_took      = 1'b0;
    out_took     = 1'b0;
    send_wait    = 0;
    recv_wait    = 0;
    send_gap_max = 5;
    recv_gap_max = 5;
    hold_cycles  = 0;
    error_count  = 0;
    min_len_cfg   = MIN_LENGTH_RESET;
    max_ascii_cfg = MAX_LENGTH_RESET;
    max_wide_cfg  = MAX_LENGTH_RESET;
    restart_file();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ascii run, wide run, printable bounds, non-printables, final byte
    push_text("Test");
    push_item(8'h1F, 1'b0);
    word = "Wide";
    for (int i = 0; i < word.len(); i++) begin
      push_item(word[i], 1'b0);
      push_item(ZERO_BYTE, 1'b0);
    end
    push_item(8'hFF, 1'b0);
    push_item(PRINTABLE_LOW, 1'b0);
    push_item(PRINTABLE_HIGH, 1'b0);
    push_item(8'h7F, 1'b0);
    push_item("q", 1'b1);
    wait_drained();

    // maximum lowered while a run is open
    push_text("xxxxxx");
    wait_drained();
    write_reg(CFG_MAX_ASCII_LENGTH, CFG_BITS'(3));
    push_item("y", 1'b1);
    wait_drained();

    // final byte closes three one-character runs; only two records fit
    write_reg(CFG_MIN_LENGTH, CFG_BITS'(1));
    write_reg(CFG_MAX_ASCII_LENGTH, CFG_BITS'(1));
    push_text("ab");
    push_item("c", 1'b1);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin mn = 12'd4;    ma = 12'd255;  mw = 12'd255;  end
        1: begin mn = 12'd1;    ma = 12'd1;    mw = 12'd1;    end
        2: begin mn = 12'd2;    ma = 12'd3;    mw = 12'd2;    end
        3: begin mn = 12'd4095; ma = 12'd4095; mw = 12'd4095; end
        4: begin mn = 12'd1;    ma = 12'd4095; mw = 12'd4095; end
        5: begin mn = 12'd0;    ma = 12'd0;    mw = 12'd0;    end
        6: begin mn = 12'd1;    ma = 12'd3;    mw = 12'd2;    end
        default: begin mn = pick_length(); ma = pick_length(); mw = pick_length(); end
      endcase
      write_reg(CFG_MIN_LENGTH, mn);
      write_reg(CFG_MAX_ASCII_LENGTH, ma);
      write_reg(CFG_MAX_WIDE_LENGTH, mw);
      send_gap_max = (p % 2 == 1) ? 5 : 0;
      recv_gap_max = (p % 3 == 0) ? 0 : 5;
      if (p == PRESSURE_PHASE) begin
        send_gap_max = 0;
        hold_cycles  = 400;
      end
      queue_random_bytes(PHASE_ITEMS);
      wait_drained();
    end

    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
